// ----- rtl/rfd_pkg.sv -----
// ----------------------------------------------------------------------------
// rfd_pkg
// shared constants, status codes and helpers of the refraction direction core
// ----------------------------------------------------------------------------
package rfd_pkg;

    localparam int DATA_W            = 16;
    localparam int STATUS_W          = 2;
    localparam int S_TDATA_W         = 8 * DATA_W;
    localparam int M_TDATA_W         = 56;
    localparam int VEC_FRAC_BITS     = 14;
    localparam int INDEX_FRAC_BITS   = 13;

    localparam logic [STATUS_W-1:0] STATUS_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_TIR       = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_ZERO_IDX  = 2'd2;

    function automatic int maxi(input int a, input int b);
        return (a > b) ? a : b;
    endfunction

endpackage

// ----- rtl/refraction_direction_core.sv -----
// ----------------------------------------------------------------------------
// refraction_direction_core
// refracted ray direction by the vector form of snell's law, fixed point
// ----------------------------------------------------------------------------
// s_ channel: one word per ray hit with both indices (q3.13), the direction
// and the surface normal (q2.14). m_ channel: one word per input word with
// the refracted direction (q2.14, saturated) and a status code; the vector
// is zero on total internal reflection or a zero outgoing index.
// throughput: one word per cycle while no skid word waits, no bubbles between words.
// stages: (16 + VEC_FRAC_BITS) divider stages for the index ratio, six
// arithmetic stages, one square root stage per root bit (24 at the default
// fractions), three more arithmetic stages and the output register.
// a stall on m_tready parks one word in a skid register and then freezes
// the whole pipeline; s_tready drops only while that skid word waits.
// reset clears all valid bits; words in flight are dropped.
// ----------------------------------------------------------------------------
module refraction_direction_core #(
    parameter int VEC_FRAC_BITS   = rfd_pkg::VEC_FRAC_BITS,
    parameter int INDEX_FRAC_BITS = rfd_pkg::INDEX_FRAC_BITS
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // in_index, out_index, dir_x, dir_y, dir_z, norm_x, norm_y, norm_z
    input  logic [rfd_pkg::S_TDATA_W-1:0] s_tdata,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // ref_x, ref_y, ref_z, status, zero pad
    output logic [rfd_pkg::M_TDATA_W-1:0] m_tdata
);

    localparam int V     = VEC_FRAC_BITS;
    localparam int DW    = rfd_pkg::DATA_W;
    localparam int SUMW  = 2 * DW + 2;
    localparam int CW    = SUMW - V;
    localparam int QW    = DW + V;
    localparam longint NMAX = (longint'(65535) << V) >> INDEX_FRAC_BITS;
    localparam int NW    = $clog2(NMAX + 1);
    localparam int CCW   = rfd_pkg::maxi(2 * CW, V + 2);
    localparam int CSW   = CCW - V;
    localparam int KW    = rfd_pkg::maxi(CSW, V + 1) + 1;
    localparam int NNW   = rfd_pkg::maxi(2 * NW + 1, V + 2);
    localparam int NNSW  = NNW - V;
    localparam int PW    = rfd_pkg::maxi(NNSW + KW, V + 2);
    localparam int PTW   = PW - V;
    localparam int TW    = rfd_pkg::maxi(PTW, V + 2) + 1;
    localparam int XW    = TW - 1 + V;
    localparam int RADW  = XW + (XW % 2);
    localparam int RW    = RADW / 2;
    localparam int NCW   = rfd_pkg::maxi(NW + 1 + CW, V + 2);
    localparam int NCTW  = NCW - V;
    localparam int NDW   = rfd_pkg::maxi(NW + 1 + DW, V + 2);
    localparam int NDTW  = NDW - V;
    localparam int AW    = rfd_pkg::maxi(NCTW, RW + 1) + 1;
    localparam int AMW   = rfd_pkg::maxi(AW + DW, V + 2);
    localparam int AMTW  = AMW - V;
    localparam int RSW   = rfd_pkg::maxi(NDTW, AMTW) + 1;
    localparam int D_SIDE_W = 1 + 6 * DW;
    localparam int Q_SIDE_W = 2 + NCTW + 3 * NDTW + 3 * DW;
    localparam int OUT_W = 3 * DW + rfd_pkg::STATUS_W;

    localparam logic [NW-1:0]        NMAX_N = NW'(NMAX);
    localparam logic signed [KW-1:0] ONE_K  = KW'(longint'(1) << V);
    localparam logic signed [TW-1:0] ONE_T  = TW'(longint'(1) << V);
    localparam logic signed [RSW-1:0] SAT_HI = RSW'(32767);
    localparam logic signed [RSW-1:0] SAT_LO = -RSW'(32768);

    logic en;
    logic skid_valid_reg;
    logic out_valid_reg;
    logic [OUT_W-1:0] out_data_reg;
    logic [OUT_W-1:0] skid_data_reg;

    assign en       = !skid_valid_reg;
    assign s_tready = en;

    // ---- ratio divider
    logic [QW-1:0]       div_dividend;
    logic [D_SIDE_W-1:0] div_side_in;
    logic                div_valid;
    logic [QW-1:0]       div_quot;
    logic [D_SIDE_W-1:0] div_side;

    assign div_dividend = {s_tdata[DW-1:0], {V{1'b0}}};
    assign div_side_in  = {s_tdata[8*DW-1:2*DW], (s_tdata[2*DW-1:DW] == '0)};

    rfd_div #(
        .DVD_W  (QW),
        .DVS_W  (DW),
        .SIDE_W (D_SIDE_W)
    ) u_div (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .en          (en),
        .in_valid    (s_tvalid),
        .in_dividend (div_dividend),
        .in_divisor  (s_tdata[2*DW-1:DW]),
        .in_side     (div_side_in),
        .out_valid   (div_valid),
        .out_quot    (div_quot),
        .out_side    (div_side)
    );

    // ---- stage 1: ratio clamp, dot product terms
    logic                   v1_reg, z1_reg;
    logic [NW-1:0]          n1_reg;
    logic signed [DW-1:0]   d1_reg [3];
    logic signed [DW-1:0]   m1_reg [3];
    logic signed [2*DW-1:0] pr1_reg [3];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
        end else if (en) begin
            v1_reg <= div_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            z1_reg <= div_side[0];
            n1_reg <= (div_quot > QW'(NMAX_N)) ? NMAX_N : NW'(div_quot);
            for (int i = 0; i < 3; i++) begin
                d1_reg[i]  <= div_side[1 + DW*i +: DW];
                m1_reg[i]  <= div_side[1 + DW*(3+i) +: DW];
                pr1_reg[i] <= (2*DW)'($signed(div_side[1 + DW*i +: DW]))
                            * (2*DW)'($signed(div_side[1 + DW*(3+i) +: DW]));
            end
        end
    end

    // ---- stage 2: dot sum to c, n squared
    logic signed [SUMW-1:0] sum_next, sum_b;
    logic                   v2_reg, z2_reg;
    logic [NW-1:0]          n2_reg;
    logic signed [NNW-1:0]  nn2_reg;
    logic signed [CW-1:0]   c2_reg;
    logic signed [DW-1:0]   d2_reg [3];
    logic signed [DW-1:0]   m2_reg [3];

    always_comb begin
        sum_next = SUMW'(pr1_reg[0]) + SUMW'(pr1_reg[1]) + SUMW'(pr1_reg[2]);
        sum_b    = sum_next + $signed({{(SUMW-V){1'b0}}, {V{sum_next[SUMW-1]}}});
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v2_reg <= 1'b0;
        end else if (en) begin
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            z2_reg  <= z1_reg;
            n2_reg  <= n1_reg;
            nn2_reg <= NNW'($signed({1'b0, n1_reg})) * NNW'($signed({1'b0, n1_reg}));
            c2_reg  <= sum_b[SUMW-1:V];
            d2_reg  <= d1_reg;
            m2_reg  <= m1_reg;
        end
    end

    // ---- stage 3: products of c, n times d
    logic                   v3_reg, z3_reg;
    logic signed [CCW-1:0]  cc3_reg;
    logic signed [NCW-1:0]  nc3_reg;
    logic signed [NNSW-1:0] nns3_reg;
    logic signed [NDW-1:0]  nd3_reg [3];
    logic signed [DW-1:0]   m3_reg [3];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v3_reg <= 1'b0;
        end else if (en) begin
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            z3_reg   <= z2_reg;
            cc3_reg  <= CCW'(c2_reg) * CCW'(c2_reg);
            nc3_reg  <= NCW'($signed({1'b0, n2_reg})) * NCW'(c2_reg);
            nns3_reg <= nn2_reg[NNW-1:V];
            for (int i = 0; i < 3; i++) begin
                nd3_reg[i] <= NDW'($signed({1'b0, n2_reg})) * NDW'(d2_reg[i]);
            end
            m3_reg <= m2_reg;
        end
    end

    // ---- stage 4: k and truncations
    logic signed [NCW-1:0]  nc_b;
    logic signed [NDW-1:0]  nd_b [3];
    logic                   v4_reg, z4_reg;
    logic signed [KW-1:0]   k4_reg;
    logic signed [NCTW-1:0] nct4_reg;
    logic signed [NNSW-1:0] nns4_reg;
    logic signed [NDTW-1:0] ndt4_reg [3];
    logic signed [DW-1:0]   m4_reg [3];

    always_comb begin
        nc_b = nc3_reg + $signed({{(NCW-V){1'b0}}, {V{nc3_reg[NCW-1]}}});
        for (int i = 0; i < 3; i++) begin
            nd_b[i] = nd3_reg[i] + $signed({{(NDW-V){1'b0}}, {V{nd3_reg[i][NDW-1]}}});
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v4_reg <= 1'b0;
        end else if (en) begin
            v4_reg <= v3_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            z4_reg   <= z3_reg;
            k4_reg   <= ONE_K - KW'($signed({1'b0, cc3_reg[CCW-1:V]}));
            nct4_reg <= nc_b[NCW-1:V];
            nns4_reg <= nns3_reg;
            for (int i = 0; i < 3; i++) begin
                ndt4_reg[i] <= nd_b[i][NDW-1:V];
            end
            m4_reg <= m3_reg;
        end
    end

    // ---- stage 5: n^2 * k
    logic                   v5_reg, z5_reg;
    logic signed [PW-1:0]   p5_reg;
    logic signed [NCTW-1:0] nct5_reg;
    logic signed [NDTW-1:0] ndt5_reg [3];
    logic signed [DW-1:0]   m5_reg [3];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v5_reg <= 1'b0;
        end else if (en) begin
            v5_reg <= v4_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            z5_reg   <= z4_reg;
            p5_reg   <= PW'(nns4_reg) * PW'(k4_reg);
            nct5_reg <= nct4_reg;
            ndt5_reg <= ndt4_reg;
            m5_reg   <= m4_reg;
        end
    end

    // ---- stage 6: root argument
    logic signed [PW-1:0]   p_b;
    logic signed [TW-1:0]   t_next;
    logic                   v6_reg, z6_reg, tneg6_reg;
    logic [RADW-1:0]        rad6_reg;
    logic signed [NCTW-1:0] nct6_reg;
    logic signed [NDTW-1:0] ndt6_reg [3];
    logic signed [DW-1:0]   m6_reg [3];

    always_comb begin
        p_b    = p5_reg + $signed({{(PW-V){1'b0}}, {V{p5_reg[PW-1]}}});
        t_next = ONE_T - TW'($signed(p_b[PW-1:V]));
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v6_reg <= 1'b0;
        end else if (en) begin
            v6_reg <= v5_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            z6_reg    <= z5_reg;
            tneg6_reg <= t_next[TW-1];
            rad6_reg  <= t_next[TW-1] ? '0 : RADW'({t_next[TW-2:0], {V{1'b0}}});
            nct6_reg  <= nct5_reg;
            ndt6_reg  <= ndt5_reg;
            m6_reg    <= m5_reg;
        end
    end

    // ---- square root
    logic [Q_SIDE_W-1:0] sq_side_in;
    logic [Q_SIDE_W-1:0] sq_side;
    logic                sq_valid;
    logic [RW-1:0]       sq_root;

    assign sq_side_in = {m6_reg[2], m6_reg[1], m6_reg[0],
                         ndt6_reg[2], ndt6_reg[1], ndt6_reg[0],
                         nct6_reg, tneg6_reg, z6_reg};

    rfd_sqrt #(
        .RAD_W  (RADW),
        .SIDE_W (Q_SIDE_W)
    ) u_sqrt (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (v6_reg),
        .in_rad    (rad6_reg),
        .in_side   (sq_side_in),
        .out_valid (sq_valid),
        .out_root  (sq_root),
        .out_side  (sq_side)
    );

    // ---- stage 7: normal coefficient and status
    logic                        v7_reg;
    logic [rfd_pkg::STATUS_W-1:0] st7_reg;
    logic signed [AW-1:0]        a7_reg;
    logic signed [NDTW-1:0]      ndt7_reg [3];
    logic signed [DW-1:0]        m7_reg [3];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v7_reg <= 1'b0;
        end else if (en) begin
            v7_reg <= sq_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            if (sq_side[0]) begin
                st7_reg <= rfd_pkg::STATUS_ZERO_IDX;
            end else if (sq_side[1]) begin
                st7_reg <= rfd_pkg::STATUS_TIR;
            end else begin
                st7_reg <= rfd_pkg::STATUS_OK;
            end
            a7_reg <= AW'($signed(sq_side[2 +: NCTW])) - AW'($signed({1'b0, sq_root}));
            for (int i = 0; i < 3; i++) begin
                ndt7_reg[i] <= sq_side[2 + NCTW + NDTW*i +: NDTW];
                m7_reg[i]   <= sq_side[2 + NCTW + 3*NDTW + DW*i +: DW];
            end
        end
    end

    // ---- stage 8: coefficient times normal
    logic                        v8_reg;
    logic [rfd_pkg::STATUS_W-1:0] st8_reg;
    logic signed [AMW-1:0]       am8_reg [3];
    logic signed [NDTW-1:0]      ndt8_reg [3];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v8_reg <= 1'b0;
        end else if (en) begin
            v8_reg <= v7_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            st8_reg <= st7_reg;
            for (int i = 0; i < 3; i++) begin
                am8_reg[i] <= AMW'(a7_reg) * AMW'(m7_reg[i]);
            end
            ndt8_reg <= ndt7_reg;
        end
    end

    // ---- stage 9: final sum, saturation and zeroing on a non-ok status
    logic signed [AMW-1:0] am_b [3];
    logic signed [RSW-1:0] rs [3];
    logic [DW-1:0]         rc [3];
    logic                  v9_reg;
    logic [OUT_W-1:0]      res9_reg;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            am_b[i] = am8_reg[i]
                    + $signed({{(AMW-V){1'b0}}, {V{am8_reg[i][AMW-1]}}});
            rs[i]   = RSW'(ndt8_reg[i]) + RSW'($signed(am_b[i][AMW-1:V]));
            if (st8_reg != rfd_pkg::STATUS_OK) begin
                rc[i] = '0;
            end else if (rs[i] > SAT_HI) begin
                rc[i] = DW'(SAT_HI);
            end else if (rs[i] < SAT_LO) begin
                rc[i] = DW'(SAT_LO);
            end else begin
                rc[i] = rs[i][DW-1:0];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v9_reg <= 1'b0;
        end else if (en) begin
            v9_reg <= v8_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            res9_reg <= {st8_reg, rc[2], rc[1], rc[0]};
        end
    end

    // ---- output register and skid
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (skid_valid_reg) begin
            if (m_tready) begin
                skid_valid_reg <= 1'b0;
            end
        end else if (v9_reg) begin
            if (out_valid_reg && !m_tready) begin
                skid_valid_reg <= 1'b1;
            end else begin
                out_valid_reg <= 1'b1;
            end
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (skid_valid_reg) begin
            if (m_tready) begin
                out_data_reg <= skid_data_reg;
            end
        end else if (v9_reg) begin
            if (out_valid_reg && !m_tready) begin
                skid_data_reg <= res9_reg;
            end else begin
                out_data_reg <= res9_reg;
            end
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(rfd_pkg::M_TDATA_W - OUT_W){1'b0}}, out_data_reg};

endmodule

// ----- rtl/rfd_div.sv -----
// ----------------------------------------------------------------------------
// rfd_div
// pipelined restoring divider, one quotient bit per stage, with sideband
// ----------------------------------------------------------------------------
module rfd_div #(
    parameter int DVD_W  = 30,
    parameter int DVS_W  = 16,
    parameter int SIDE_W = 1
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              en,
    input  logic              in_valid,
    input  logic [DVD_W-1:0]  in_dividend,
    input  logic [DVS_W-1:0]  in_divisor,
    input  logic [SIDE_W-1:0] in_side,
    output logic              out_valid,
    output logic [DVD_W-1:0]  out_quot,
    output logic [SIDE_W-1:0] out_side
);

    logic              v_reg    [DVD_W];
    logic [DVS_W-1:0]  rem_reg  [DVD_W];
    logic [DVD_W-1:0]  dq_reg   [DVD_W];
    logic [DVS_W-1:0]  dvs_reg  [DVD_W];
    logic [SIDE_W-1:0] side_reg [DVD_W];

    for (genvar j = 0; j < DVD_W; j++) begin : g_stage
        logic              v_in;
        logic [DVS_W-1:0]  rem_in;
        logic [DVD_W-1:0]  dq_in;
        logic [DVS_W-1:0]  dvs_in;
        logic [SIDE_W-1:0] side_in;
        logic [DVS_W:0]    trial;
        logic [DVS_W-1:0]  rem_next;
        logic              bit_next;

        if (j == 0) begin : g_first
            assign v_in    = in_valid;
            assign rem_in  = '0;
            assign dq_in   = in_dividend;
            assign dvs_in  = in_divisor;
            assign side_in = in_side;
        end else begin : g_rest
            assign v_in    = v_reg[j-1];
            assign rem_in  = rem_reg[j-1];
            assign dq_in   = dq_reg[j-1];
            assign dvs_in  = dvs_reg[j-1];
            assign side_in = side_reg[j-1];
        end

        always_comb begin
            trial = {rem_in, dq_in[DVD_W-1]};
            if (trial >= {1'b0, dvs_in}) begin
                rem_next = DVS_W'(trial - {1'b0, dvs_in});
                bit_next = 1'b1;
            end else begin
                rem_next = trial[DVS_W-1:0];
                bit_next = 1'b0;
            end
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                v_reg[j] <= 1'b0;
            end else if (en) begin
                v_reg[j] <= v_in;
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                rem_reg[j]  <= rem_next;
                dq_reg[j]   <= {dq_in[DVD_W-2:0], bit_next};
                dvs_reg[j]  <= dvs_in;
                side_reg[j] <= side_in;
            end
        end
    end

    assign out_valid = v_reg[DVD_W-1];
    assign out_quot  = dq_reg[DVD_W-1];
    assign out_side  = side_reg[DVD_W-1];

endmodule

// ----- rtl/rfd_sqrt.sv -----
// ----------------------------------------------------------------------------
// rfd_sqrt
// pipelined integer square root, one root bit per stage, with sideband
// ----------------------------------------------------------------------------
module rfd_sqrt #(
    parameter int RAD_W  = 66,
    parameter int SIDE_W = 1
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 en,
    input  logic                 in_valid,
    input  logic [RAD_W-1:0]     in_rad,
    input  logic [SIDE_W-1:0]    in_side,
    output logic                 out_valid,
    output logic [RAD_W/2-1:0]   out_root,
    output logic [SIDE_W-1:0]    out_side
);

    localparam int RW = RAD_W / 2;

    logic              v_reg    [RW];
    logic [RW:0]       rem_reg  [RW];
    logic [RAD_W-1:0]  x_reg    [RW];
    logic [RW-1:0]     root_reg [RW];
    logic [SIDE_W-1:0] side_reg [RW];

    for (genvar j = 0; j < RW; j++) begin : g_stage
        logic              v_in;
        logic [RW:0]       rem_in;
        logic [RAD_W-1:0]  x_in;
        logic [RW-1:0]     root_in;
        logic [SIDE_W-1:0] side_in;
        logic [RW+2:0]     rem_sh;
        logic [RW+2:0]     trial;
        logic [RW:0]       rem_next;
        logic              bit_next;

        if (j == 0) begin : g_first
            assign v_in    = in_valid;
            assign rem_in  = '0;
            assign x_in    = in_rad;
            assign root_in = '0;
            assign side_in = in_side;
        end else begin : g_rest
            assign v_in    = v_reg[j-1];
            assign rem_in  = rem_reg[j-1];
            assign x_in    = x_reg[j-1];
            assign root_in = root_reg[j-1];
            assign side_in = side_reg[j-1];
        end

        always_comb begin
            rem_sh = {rem_in, x_in[RAD_W-1:RAD_W-2]};
            trial  = {1'b0, root_in, 2'b01};
            if (rem_sh >= trial) begin
                rem_next = (RW+1)'(rem_sh - trial);
                bit_next = 1'b1;
            end else begin
                rem_next = rem_sh[RW:0];
                bit_next = 1'b0;
            end
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                v_reg[j] <= 1'b0;
            end else if (en) begin
                v_reg[j] <= v_in;
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                rem_reg[j]  <= rem_next;
                x_reg[j]    <= {x_in[RAD_W-3:0], 2'b00};
                root_reg[j] <= {root_in[RW-2:0], bit_next};
                side_reg[j] <= side_in;
            end
        end
    end

    assign out_valid = v_reg[RW-1];
    assign out_root  = root_reg[RW-1];
    assign out_side  = side_reg[RW-1];

endmodule

// ----- sim/refraction_direction_core_tb.sv -----
// ----------------------------------------------------------------------------
// refraction_direction_core_tb
// drives ray hits into the refraction core and checks every refracted
// direction and status against a fixed point predictor of snell's law
// ----------------------------------------------------------------------------
module refraction_direction_core_tb;

    localparam longint WMAX      = (64'sd1 <<< 61) - 1;
    localparam int     VF        = rfd_pkg::VEC_FRAC_BITS;
    localparam longint CYCLE_CAP = 2000000;

    typedef struct packed {
        logic [15:0] rx;
        logic [15:0] ry;
        logic [15:0] rz;
        logic [1:0]  st;
    } refr_t;

    function automatic longint clampw(input longint x);
        if (x > WMAX) return WMAX;
        if (x < -WMAX) return -WMAX;
        return x;
    endfunction

    // product truncated toward zero, saturated
    function automatic longint fmul(input longint a, input longint b);
        logic [127:0] p;
        logic [127:0] r;
        logic         neg;
        neg = (a < 0) != (b < 0);
        p = 128'(a < 0 ? -a : a) * 128'(b < 0 ? -b : b);
        r = p >> VF;
        if (r > 128'(WMAX)) r = 128'(WMAX);
        return neg ? -longint'(r[63:0]) : longint'(r[63:0]);
    endfunction

    function automatic longint isqrt_scaled(input longint t);
        logic [127:0] v;
        logic [127:0] cand;
        logic [63:0]  r;
        v = 128'(t) << VF;
        r = 0;
        for (int b = 47; b >= 0; b--) begin
            cand = 128'(r | (64'd1 << b));
            if (cand * cand <= v) r = cand[63:0];
        end
        return longint'(r);
    endfunction

    function automatic logic [15:0] sat16(input longint x);
        if (x > 32767) x = 32767;
        if (x < -32768) x = -32768;
        return x[15:0];
    endfunction

    function automatic refr_t refract(input logic [127:0] w);
        refr_t  o;
        longint d[3], m[3];
        longint sum, n, c, k, t, s, a, nmax, ratio;
        o = '0;
        if (w[31:16] == 0) begin
            o.st = rfd_pkg::STATUS_ZERO_IDX;
            return o;
        end
        for (int i = 0; i < 3; i++) begin
            d[i] = longint'($signed(w[32+16*i +: 16]));
            m[i] = longint'($signed(w[80+16*i +: 16]));
        end
        ratio = (longint'(w[15:0]) << VF) / longint'(w[31:16]);
        nmax = (longint'(65535) << VF) >>> rfd_pkg::INDEX_FRAC_BITS;
        n = ratio > nmax ? nmax : ratio;
        sum = d[0]*m[0] + d[1]*m[1] + d[2]*m[2];
        c = sum < 0 ? -((-sum) >>> VF) : (sum >>> VF);
        k = clampw((64'sd1 <<< VF) - fmul(c, c));
        t = clampw((64'sd1 <<< VF) - fmul(fmul(n, n), k));
        if (t < 0) begin
            o.st = rfd_pkg::STATUS_TIR;
            return o;
        end
        s = isqrt_scaled(t);
        a = clampw(fmul(n, c) - s);
        o.rx = sat16(clampw(fmul(n, d[0]) + fmul(a, m[0])));
        o.ry = sat16(clampw(fmul(n, d[1]) + fmul(a, m[1])));
        o.rz = sat16(clampw(fmul(n, d[2]) + fmul(a, m[2])));
        o.st = rfd_pkg::STATUS_OK;
        return o;
    endfunction

    class refr_scoreboard;
        refr_t pending[$];
        int    errors;

        function void note_hit(input logic [127:0] w);
            pending.push_back(refract(w));
        endfunction

        function void check_word(input logic [rfd_pkg::M_TDATA_W-1:0] w);
            refr_t got, exp;
            got.rx = w[15:0];
            got.ry = w[31:16];
            got.rz = w[47:32];
            got.st = w[49:48];
            if (pending.size() == 0) begin
                $display("%0t unexpected word %h", $time, w);
                errors++;
                return;
            end
            exp = pending.pop_front();
            if (got.rx !== exp.rx) begin
                $display("%0t ref_x exp %h got %h", $time, exp.rx, got.rx);
                errors++;
            end
            if (got.ry !== exp.ry) begin
                $display("%0t ref_y exp %h got %h", $time, exp.ry, got.ry);
                errors++;
            end
            if (got.rz !== exp.rz) begin
                $display("%0t ref_z exp %h got %h", $time, exp.rz, got.rz);
                errors++;
            end
            if (got.st !== exp.st) begin
                $display("%0t status exp %0d got %0d", $time, exp.st, got.st);
                errors++;
            end
        endfunction
    endclass

    logic                          aclk = 0;
    logic                          aresetn = 0;
    logic                          s_tvalid = 0;
    logic                          s_tready;
    logic [rfd_pkg::S_TDATA_W-1:0] s_tdata = '0;
    logic                          m_tvalid;
    logic                          m_tready = 0;
    logic [rfd_pkg::M_TDATA_W-1:0] m_tdata;

    refr_scoreboard board = new();
    int     src_idle = 0;
    int     sink_stall = 0;
    longint cycles = 0;

    refraction_direction_core dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
    );

    always #4 aclk = ~aclk;

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_CAP) begin
            $display("refraction_direction_core: mismatch");
            $finish;
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) board.check_word(m_tdata);
        m_tready <= ($urandom_range(99) >= sink_stall);
    end

    function automatic logic [15:0] rand_vec();
        case ($urandom_range(5))
            0: return 16'h4000;
            1: return 16'hc000;
            2: return 16'($signed($urandom_range(32768)) - 16384);
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic logic [15:0] rand_index();
        case ($urandom_range(9))
            0: return 16'h0000;
            1: return 16'hffff;
            2: return 16'h2000;
            default: return 16'($urandom_range(20000, 6000));
        endcase
    endfunction

    task automatic send_hit(input logic [127:0] w);
        while ($urandom_range(99) < src_idle) begin
            s_tvalid <= 0;
            @(posedge aclk);
        end
        s_tvalid <= 1;
        s_tdata  <= w;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        board.note_hit(w);
    endtask

    task automatic send_parts(input logic [15:0] ni, no, dx, dy, dz, mx, my, mz);
        send_hit({mz, my, mx, dz, dy, dx, no, ni});
    endtask

    initial begin
        repeat (8) @(posedge aclk);
        aresetn <= 1;
        @(posedge aclk);
        send_parts(16'h2000, 16'h2000, 16'h0000, 16'h0000, 16'hc000,
                   16'h0000, 16'h0000, 16'h4000);
        send_parts(16'h2000, 16'h0000, 16'h4000, 16'h0000, 16'h0000,
                   16'h0000, 16'h4000, 16'h0000);
        send_parts(16'h3000, 16'h2000, 16'h4000, 16'h0000, 16'h0000,
                   16'h0000, 16'h4000, 16'h0000);
        send_parts(16'hffff, 16'h0001, 16'h7fff, 16'h8000, 16'h7fff,
                   16'h8000, 16'h7fff, 16'h8000);
        send_parts(16'h0000, 16'hffff, 16'h8000, 16'h8000, 16'h8000,
                   16'h8000, 16'h8000, 16'h8000);
        send_parts(16'h2000, 16'h2000, 16'h7fff, 16'h7fff, 16'h7fff,
                   16'h7fff, 16'h7fff, 16'h7fff);
        send_parts(16'h2000, 16'h2000, 16'h4000, 16'h0000, 16'h0000,
                   16'h4000, 16'h0000, 16'h0000);
        send_parts(16'hffff, 16'hffff, 16'hffff, 16'h0001, 16'h0000,
                   16'h0001, 16'hffff, 16'h0000);
        for (int ph = 0; ph < 4; ph++) begin
            src_idle   = (ph == 1 || ph == 3) ? (ph == 1 ? 70 : 27) : 0;
            sink_stall = (ph == 2 || ph == 3) ? (ph == 2 ? 70 : 27) : 0;
            for (int i = 0; i < 490; i++) begin
                if ($urandom_range(9) == 0)
                    send_hit({$urandom, $urandom, $urandom, $urandom});
                else
                    send_parts(rand_index(), rand_index(), rand_vec(), rand_vec(),
                               rand_vec(), rand_vec(), rand_vec(), rand_vec());
            end
        end
        s_tvalid <= 0;
        sink_stall = 0;
        while (board.pending.size() != 0) @(posedge aclk);
        repeat (100) @(posedge aclk);
        if (board.errors == 0)
            $display("refraction_direction_core: match");
        else
            $display("refraction_direction_core: mismatch");
        $finish;
    end
endmodule

// ----- sim.f -----
rtl/rfd_pkg.sv
rtl/rfd_div.sv
rtl/rfd_sqrt.sv
rtl/refraction_direction_core.sv
sim/refraction_direction_core_tb.sv
